[hdl/tle_pkg.sv]
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types and constants of the terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam logic [7:0] C_BS      = 8'h08;
    localparam logic [7:0] C_DEL     = 8'h7F;
    localparam logic [7:0] C_CR      = 8'h0D;
    localparam logic [7:0] C_LF      = 8'h0A;
    localparam logic [7:0] C_SP      = 8'h20;
    localparam logic [7:0] C_CARET   = 8'h5E;
    localparam logic [7:0] C_MARK_C  = 8'h43;
    localparam logic [7:0] C_MARK_BS = 8'h5C;
    localparam logic [7:0] C_MARK_Z  = 8'h5A;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CANON = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSP  = 3'd5;

    localparam logic [1:0] SIG_INTR = 2'd0;
    localparam logic [1:0] SIG_QUIT = 2'd1;
    localparam logic [1:0] SIG_SUSP = 2'd2;

    typedef enum logic [1:0] {
        K_ECHO  = 2'd0,
        K_SIG   = 2'd1,
        K_READ  = 2'd2,
        K_EMPTY = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        D_RAW    = 3'd0,
        D_MAPPED = 3'd1,
        D_CARET  = 3'd2,
        D_MARK   = 3'd3,
        D_LF     = 3'd4,
        D_BS     = 3'd5,
        D_SP     = 3'd6,
        D_RING   = 3'd7
    } t_dsel;

    typedef struct packed {
        logic  load;
        logic  emit;
        t_kind kind;
        t_dsel dsel;
        logic  last;
        logic  line_wr;
        logic  len_dec;
        logic  len_clr;
        logic  idx_clr;
        logic  line_rd;
        logic  idx_inc;
        logic  pbyte_rx;
        logic  ring_rd;
        logic  pop;
        logic  push;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic sig_hit;
        logic is_erase;
        logic canon;
        logic echo_en;
        logic line_empty;
        logic is_lf;
        logic idx_done;
        logic readable;
        logic ring_full;
        logic out_free;
    } t_status;

endpackage

[hdl/tle_ram.sv]
// ----------------------------------------------------------------------------
// tle_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/tle_ctrl.sv]
// ----------------------------------------------------------------------------
// tle_ctrl
// Sequencer: decodes an item and steps echo, ring and commit operations.
// ----------------------------------------------------------------------------
module tle_ctrl
    import tle_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_RD1, S_EMPTY, S_SIG0, S_SIG1, S_SIG2, S_SIG3,
        S_ERA0, S_ERA1, S_ERA2, S_PCHK, S_PWR, S_ECHO, S_CLRD, S_CLLD
    } t_state;

    t_state r_state, n_state;
    logic   r_commit, n_commit;
    t_cmd   c;

    always_comb begin
        c        = '0;
        c.kind   = K_ECHO;
        c.dsel   = D_RAW;
        n_state  = r_state;
        n_commit = r_commit;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    c.load  = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_st.op) begin
                    if (i_st.readable) begin
                        c.ring_rd = 1'b1;
                        n_state   = S_RD1;
                    end else begin
                        n_state = S_EMPTY;
                    end
                end else if (i_st.sig_hit) begin
                    n_state = i_st.echo_en ? S_SIG0 : S_SIG3;
                end else if (!i_st.canon) begin
                    c.pbyte_rx = 1'b1;
                    n_commit   = 1'b0;
                    n_state    = S_PCHK;
                end else if (i_st.is_erase) begin
                    if (!i_st.line_empty) begin
                        c.len_dec = 1'b1;
                        n_state   = i_st.echo_en ? S_ERA0 : S_IDLE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    c.line_wr = 1'b1;
                    if (i_st.echo_en) begin
                        n_state = S_ECHO;
                    end else if (i_st.is_lf) begin
                        c.idx_clr = 1'b1;
                        n_commit  = 1'b1;
                        n_state   = S_CLRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RD1: begin
                c.kind = K_READ;
                c.dsel = D_RING;
                c.last = 1'b1;
                if (i_st.out_free) begin
                    c.emit  = 1'b1;
                    c.pop   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EMPTY: begin
                c.kind = K_EMPTY;
                c.last = 1'b1;
                if (i_st.out_free) begin
                    c.emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SIG0, S_SIG1, S_SIG2, S_ERA0, S_ERA1, S_ERA2: begin
                case (r_state)
                    S_SIG0:  c.dsel = D_CARET;
                    S_SIG1:  c.dsel = D_MARK;
                    S_SIG2:  c.dsel = D_LF;
                    S_ERA1:  c.dsel = D_SP;
                    default: c.dsel = D_BS;
                endcase
                c.last = (r_state == S_ERA2);
                if (i_st.out_free) begin
                    c.emit = 1'b1;
                    case (r_state)
                        S_SIG0:  n_state = S_SIG1;
                        S_SIG1:  n_state = S_SIG2;
                        S_SIG2:  n_state = S_SIG3;
                        S_ERA0:  n_state = S_ERA1;
                        S_ERA1:  n_state = S_ERA2;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SIG3: begin
                c.kind = K_SIG;
                c.last = 1'b1;
                if (i_st.out_free) begin
                    c.emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PCHK: begin
                // fetch oldest byte in case the push overwrites it
                c.ring_rd = 1'b1;
                n_state   = S_PWR;
            end
            S_PWR: begin
                c.push = 1'b1;
                c.pop  = i_st.ring_full;
                if (r_commit) begin
                    n_state = S_CLRD;
                end else begin
                    n_state = i_st.echo_en ? S_ECHO : S_IDLE;
                end
            end
            S_ECHO: begin
                c.dsel = D_MAPPED;
                c.last = 1'b1;
                if (i_st.out_free) begin
                    c.emit = 1'b1;
                    if (i_st.is_lf) begin
                        c.idx_clr = 1'b1;
                        n_commit  = 1'b1;
                        n_state   = S_CLRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CLRD: begin
                if (i_st.idx_done) begin
                    c.len_clr = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    c.line_rd = 1'b1;
                    n_state   = S_CLLD;
                end
            end
            S_CLLD: begin
                c.idx_inc = 1'b1;
                n_state   = S_PCHK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_commit <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_commit <= n_commit;
        end
    end

    assign o_cmd   = c;
    assign o_ready = (r_state == S_IDLE);
endmodule

[hdl/tle_dp.sv]
// ----------------------------------------------------------------------------
// tle_dp
// Datapath: config registers, line buffer, cooked ring and output register.
// ----------------------------------------------------------------------------
module tle_dp
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = 256,
    parameter int RING_CAP   = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_op,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output t_kind                o_kind,
    output logic [7:0]           o_data_byte,
    output logic [1:0]           o_signal_code,
    output logic                 o_line_end,
    output logic                 o_last,
    input  t_cmd                 i_cmd,
    output t_status              o_st
);
    localparam int LAW = $clog2(LINE_DEPTH);
    localparam int LW  = $clog2(LINE_DEPTH + 1);
    localparam int RAW = $clog2(RING_CAP);
    localparam int RW  = $clog2(RING_CAP + 1);

    logic       r_canon, r_echo, r_sig_en;
    logic [7:0] r_intr, r_quit, r_susp;

    logic          r_op;
    logic [7:0]    r_byte, r_pbyte;
    logic [LW-1:0] r_len, r_idx;
    logic [RAW-1:0] r_head, r_tail;
    logic [RW-1:0]  r_count, r_nl;

    logic       r_ovalid, r_olast, r_olend;
    t_kind      r_okind;
    logic [7:0] r_odata;
    logic [1:0] r_osig;

    logic [7:0] w_line_rdata, w_ring_rdata, w_mapped, w_mark, w_dout;
    logic [1:0] w_sig_code;
    logic       w_sig_hit, w_room, w_full, w_push_lf, w_pop_lf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canon  <= 1'b1;
            r_echo   <= 1'b1;
            r_sig_en <= 1'b1;
            r_intr   <= 8'd3;
            r_quit   <= 8'd28;
            r_susp   <= 8'd26;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CANON: r_canon  <= i_cfg_data[0];
                CFG_ECHO:  r_echo   <= i_cfg_data[0];
                CFG_SIG:   r_sig_en <= i_cfg_data[0];
                CFG_INTR:  r_intr   <= i_cfg_data;
                CFG_QUIT:  r_quit   <= i_cfg_data;
                CFG_SUSP:  r_susp   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_sig_hit  = r_sig_en;
        w_sig_code = SIG_INTR;
        w_mark     = C_MARK_C;
        if (r_byte == r_intr) begin
            w_sig_code = SIG_INTR;
            w_mark     = C_MARK_C;
        end else if (r_byte == r_quit) begin
            w_sig_code = SIG_QUIT;
            w_mark     = C_MARK_BS;
        end else if (r_byte == r_susp) begin
            w_sig_code = SIG_SUSP;
            w_mark     = C_MARK_Z;
        end else begin
            w_sig_hit = 1'b0;
        end
    end

    assign w_mapped  = (r_canon && r_byte == C_CR) ? C_LF : r_byte;
    assign w_room    = (r_len < LW'(LINE_DEPTH));
    assign w_full    = (r_count == RW'(RING_CAP));
    assign w_push_lf = i_cmd.push && (r_pbyte == C_LF);
    assign w_pop_lf  = i_cmd.pop && (w_ring_rdata == C_LF);

    tle_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.line_wr && w_room),
        .i_waddr (r_len[LAW-1:0]),
        .i_wdata (w_mapped),
        .i_re    (i_cmd.line_rd),
        .i_raddr (r_idx[LAW-1:0]),
        .o_rdata (w_line_rdata)
    );

    tle_ram #(.WIDTH(8), .DEPTH(RING_CAP)) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_head),
        .i_wdata (r_pbyte),
        .i_re    (i_cmd.ring_rd),
        .i_raddr (r_tail),
        .o_rdata (w_ring_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_byte <= i_rx_byte;
        end
        if (i_cmd.pbyte_rx) begin
            r_pbyte <= r_byte;
        end else if (i_cmd.idx_inc) begin
            r_pbyte <= w_line_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_idx   <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_nl    <= '0;
        end else begin
            if (i_cmd.len_clr) begin
                r_len <= '0;
            end else if (i_cmd.len_dec) begin
                r_len <= r_len - LW'(1);
            end else if (i_cmd.line_wr && w_room) begin
                r_len <= r_len + LW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + LW'(1);
            end
            if (i_cmd.push) begin
                r_head <= (r_head == RAW'(RING_CAP - 1)) ? '0 : r_head + RAW'(1);
            end
            if (i_cmd.pop) begin
                r_tail <= (r_tail == RAW'(RING_CAP - 1)) ? '0 : r_tail + RAW'(1);
            end
            if (i_cmd.push && !i_cmd.pop) begin
                r_count <= r_count + RW'(1);
            end else if (i_cmd.pop && !i_cmd.push) begin
                r_count <= r_count - RW'(1);
            end
            if (w_push_lf && !w_pop_lf) begin
                r_nl <= r_nl + RW'(1);
            end else if (w_pop_lf && !w_push_lf) begin
                r_nl <= r_nl - RW'(1);
            end
        end
    end

    always_comb begin
        case (i_cmd.dsel)
            D_RAW:    w_dout = r_byte;
            D_MAPPED: w_dout = w_mapped;
            D_CARET:  w_dout = C_CARET;
            D_MARK:   w_dout = w_mark;
            D_LF:     w_dout = C_LF;
            D_BS:     w_dout = C_BS;
            D_SP:     w_dout = C_SP;
            D_RING:   w_dout = w_ring_rdata;
            default:  w_dout = r_byte;
        endcase
        if (i_cmd.kind == K_EMPTY) begin
            w_dout = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_okind <= i_cmd.kind;
            r_odata <= w_dout;
            r_osig  <= (i_cmd.kind == K_SIG) ? w_sig_code : 2'd0;
            r_olend <= (i_cmd.kind == K_READ) && r_canon && (w_ring_rdata == C_LF);
            r_olast <= i_cmd.last;
        end
    end

    assign o_st.op         = r_op;
    assign o_st.sig_hit    = w_sig_hit;
    assign o_st.is_erase   = (r_byte == C_BS) || (r_byte == C_DEL);
    assign o_st.canon      = r_canon;
    assign o_st.echo_en    = r_echo;
    assign o_st.line_empty = (r_len == '0);
    assign o_st.is_lf      = r_canon && (w_mapped == C_LF);
    assign o_st.idx_done   = (r_idx == r_len);
    assign o_st.readable   = (r_count != '0) && (!r_canon || r_nl != '0);
    assign o_st.ring_full  = w_full;
    assign o_st.out_free   = !r_ovalid || i_out_ready;

    assign o_out_valid   = r_ovalid;
    assign o_kind        = r_okind;
    assign o_data_byte   = r_odata;
    assign o_signal_code = r_osig;
    assign o_line_end    = r_olend;
    assign o_last        = r_olast;
endmodule

[hdl/tty_line_editor.sv]
// ----------------------------------------------------------------------------
// tty_line_editor
// Terminal line discipline with canonical line editing and a cooked ring.
// ----------------------------------------------------------------------------
// One input word at a time: a receive or read word is taken only when the
// previous one has finished, including any output stall. A newline in
// canonical mode copies the line into the ring through the single-port-read
// line RAM byte by byte (line read, index step, oldest-byte fetch, push),
// holding off input until the commit ends. Results leave through an output
// register, one word per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module tty_line_editor
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = 256,
    parameter int RING_CAP   = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // [7:0] rx_byte
    input  logic                 i_s_tuser,   // [0] op
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [15:0]          o_m_tdata,   // [7:0] data_byte, [9:8] signal_code,
                                              // [10] line_end, rest zero
    output logic [1:0]           o_m_tuser,   // [1:0] kind
    output logic                 o_m_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);
    t_cmd       w_cmd;
    t_status    w_st;
    t_kind      w_kind;
    logic [7:0] w_data;
    logic [1:0] w_sig;
    logic       w_lend;

    tle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    tle_dp #(.LINE_DEPTH(LINE_DEPTH), .RING_CAP(RING_CAP)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_s_tuser),
        .i_rx_byte     (i_s_tdata),
        .i_out_ready   (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_kind        (w_kind),
        .o_data_byte   (w_data),
        .o_signal_code (w_sig),
        .o_line_end    (w_lend),
        .o_last        (o_m_tlast),
        .i_cmd         (w_cmd),
        .o_st          (w_st)
    );

    assign o_m_tdata   = {5'd0, w_lend, w_sig, w_data};
    assign o_m_tuser   = w_kind;
    assign o_cfg_ready = 1'b1;
endmodule

[sim/tb_tty_line_editor.sv]
// ----------------------------------------------------------------------------
// tb_tty_line_editor
// Self-checking bench for the terminal line editor.
// ----------------------------------------------------------------------------
// Words go in on the slave stream with random gaps and come back on the
// master stream under random backpressure. A behavioral model of the line
// buffer and cooked ring predicts every output word; each one is compared
// field by field against the oldest pending prediction. A directed table
// runs first, then random phases under several register settings.
// ----------------------------------------------------------------------------
module tb_tty_line_editor;
    import tle_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH = 256;
    localparam int RING_CAP   = 1024;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [1:0] sig;
        logic       lend;
        logic       last;
    } t_out_word;

    // directed row: op, byte, whether outputs are typed in, count, words
    typedef struct {
        logic        op;
        logic [7:0]  rx;
        bit          typed;
        int          n;
        t_out_word   w [4];
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata;
    logic                 i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [15:0]          o_m_tdata;
    logic [1:0]           o_m_tuser;
    logic                 o_m_tlast;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    tty_line_editor #(.LINE_DEPTH(LINE_DEPTH), .RING_CAP(RING_CAP)) u_top (.*);

    // editor model state
    logic [7:0] line_buf [LINE_DEPTH];
    int         line_len;
    logic [7:0] ring_buf [RING_CAP];
    int         ring_wr, ring_rd, ring_cnt, ring_lf;
    logic       m_canon, m_echo, m_sig;
    logic [7:0] m_intr, m_quit, m_susp;

    t_out_word  pending_words [$];
    t_out_word  step_words [$];
    int         errors;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void add_word(t_kind k, logic [7:0] d, logic [1:0] s, logic le);
        t_out_word w;
        w.kind = k; w.data = d; w.sig = s; w.lend = le; w.last = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void echo_byte(logic [7:0] b);
        if (m_echo) add_word(K_ECHO, b, 2'd0, 1'b0);
    endfunction

    function automatic logic [7:0] ring_take();
        logic [7:0] b;
        b = ring_buf[ring_rd];
        ring_rd = (ring_rd + 1) % RING_CAP;
        ring_cnt--;
        if (b == C_LF) ring_lf--;
        return b;
    endfunction

    function automatic void ring_put(logic [7:0] b);
        if (ring_cnt >= RING_CAP) void'(ring_take());
        ring_buf[ring_wr] = b;
        ring_wr = (ring_wr + 1) % RING_CAP;
        ring_cnt++;
        if (b == C_LF) ring_lf++;
    endfunction

    // computes the words one input word causes and queues them
    function automatic void predict_editor(logic op, logic [7:0] rx);
        logic [7:0] b;
        logic [7:0] mark;
        logic [1:0] code;
        bit         hit;
        step_words.delete();
        b = rx;
        hit = 1'b0;
        if (op) begin
            if (!(m_canon ? ring_lf != 0 : ring_cnt != 0) || ring_cnt == 0) begin
                add_word(K_EMPTY, 8'd0, 2'd0, 1'b0);
            end else begin
                b = ring_take();
                add_word(K_READ, b, 2'd0, m_canon && b == C_LF);
            end
        end else begin
            if (m_sig) begin
                hit = 1'b1;
                if (b == m_intr) begin
                    code = SIG_INTR; mark = C_MARK_C;
                end else if (b == m_quit) begin
                    code = SIG_QUIT; mark = C_MARK_BS;
                end else if (b == m_susp) begin
                    code = SIG_SUSP; mark = C_MARK_Z;
                end else begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                echo_byte(C_CARET);
                echo_byte(mark);
                echo_byte(C_LF);
                add_word(K_SIG, b, code, 1'b0);
            end else if (!m_canon) begin
                ring_put(b);
                echo_byte(b);
            end else if (b == C_BS || b == C_DEL) begin
                if (line_len > 0) begin
                    line_len--;
                    echo_byte(C_BS);
                    echo_byte(C_SP);
                    echo_byte(C_BS);
                end
            end else begin
                if (b == C_CR) b = C_LF;
                if (line_len < LINE_DEPTH) begin
                    line_buf[line_len] = b;
                    line_len++;
                end
                echo_byte(b);
                if (b == C_LF) begin
                    for (int i = 0; i < line_len; i++) ring_put(line_buf[i]);
                    line_len = 0;
                end
            end
        end
        if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
        foreach (step_words[i]) pending_words.push_back(step_words[i]);
    endfunction

    // output side: random stalls, compare at the rising edge
    initial begin
        t_out_word got;
        t_out_word want;
        int        gap;
        i_m_tready = 1'b0;
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            repeat (gap) @(negedge i_clk);
            i_m_tready = 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            got.kind = t_kind'(o_m_tuser);
            got.data = o_m_tdata[7:0];
            got.sig  = o_m_tdata[9:8];
            got.lend = o_m_tdata[10];
            got.last = o_m_tlast;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word kind=%0d data=%h", $time, got.kind, got.data);
                errors++;
            end else begin
                want = pending_words.pop_front();
                if (got.kind !== want.kind || got.data !== want.data ||
                    got.sig !== want.sig || got.lend !== want.lend ||
                    got.last !== want.last) begin
                    $display("%0t: mismatch expected k=%0d d=%h s=%0d le=%b l=%b",
                             $time, want.kind, want.data, want.sig, want.lend, want.last);
                    $display("%0t:          actual   k=%0d d=%h s=%0d le=%b l=%b",
                             $time, got.kind, got.data, got.sig, got.lend, got.last);
                    errors++;
                end
            end
            @(negedge i_clk);
            i_m_tready = 1'b0;
        end
    end

    task automatic send_word(logic op, logic [7:0] rx);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        repeat (gap) @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tuser  = op;
        i_s_tdata  = rx;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_editor(op, rx);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (pending_words.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        // a quiet erase, an ignored word or a line commit may still be in flight
        repeat (4) @(negedge i_clk);
        while (!o_s_tready && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_CANON: m_canon = val[0];
            CFG_ECHO:  m_echo  = val[0];
            CFG_SIG:   m_sig   = val[0];
            CFG_INTR:  m_intr  = val;
            CFG_QUIT:  m_quit  = val;
            CFG_SUSP:  m_susp  = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_out_word mk(t_kind k, logic [7:0] d, logic [1:0] s,
                                      logic le, logic l);
        t_out_word w;
        w.kind = k; w.data = d; w.sig = s; w.lend = le; w.last = l;
        return w;
    endfunction

    // random traffic; reads mixed at random with printable bytes, line ends, erases, signal and random bytes
    task automatic random_phase(int count);
        int         sel;
        logic [7:0] b;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                send_word(1'b1, 8'($urandom));
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 55)      b = 8'($urandom_range(8'h20, 8'h7E));
                else if (sel < 67) b = (sel & 1) ? C_CR : C_LF;
                else if (sel < 77) b = (sel & 1) ? C_BS : C_DEL;
                else if (sel < 85) begin
                    case ($urandom_range(0, 2))
                        0: b = m_intr;
                        1: b = m_quit;
                        default: b = m_susp;
                    endcase
                end else b = 8'($urandom);
                send_word(1'b0, b);
            end
        end
    endtask

    initial begin
        t_row rows [$];
        t_row r;
        errors = 0;
        line_len = 0; ring_wr = 0; ring_rd = 0; ring_cnt = 0; ring_lf = 0;
        m_canon = 1'b1; m_echo = 1'b1; m_sig = 1'b1;
        m_intr = 8'd3; m_quit = 8'd28; m_susp = 8'd26;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0; i_s_tdata = 8'd0; i_s_tuser = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = CFG_CANON; i_cfg_data = 8'd0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // read on empty ring, erase on empty line, signals, line edit, extremes
        r = '{op: 1'b1, rx: 8'hFF, typed: 1, n: 1, w: '{default: '0}};
        r.w[0] = mk(K_EMPTY, 8'd0, 2'd0, 1'b0, 1'b1); rows.push_back(r);
        r = '{op: 1'b0, rx: C_BS, typed: 1, n: 0, w: '{default: '0}}; rows.push_back(r);
        r = '{op: 1'b0, rx: 8'd3, typed: 1, n: 4, w: '{default: '0}};
        r.w[0] = mk(K_ECHO, C_CARET, 2'd0, 1'b0, 1'b0);
        r.w[1] = mk(K_ECHO, C_MARK_C, 2'd0, 1'b0, 1'b0);
        r.w[2] = mk(K_ECHO, C_LF, 2'd0, 1'b0, 1'b0);
        r.w[3] = mk(K_SIG, 8'd3, SIG_INTR, 1'b0, 1'b1); rows.push_back(r);
        r = '{op: 1'b0, rx: 8'd28, typed: 1, n: 4, w: '{default: '0}};
        r.w[0] = mk(K_ECHO, C_CARET, 2'd0, 1'b0, 1'b0);
        r.w[1] = mk(K_ECHO, C_MARK_BS, 2'd0, 1'b0, 1'b0);
        r.w[2] = mk(K_ECHO, C_LF, 2'd0, 1'b0, 1'b0);
        r.w[3] = mk(K_SIG, 8'd28, SIG_QUIT, 1'b0, 1'b1); rows.push_back(r);
        r = '{op: 1'b0, rx: 8'd26, typed: 1, n: 4, w: '{default: '0}};
        r.w[0] = mk(K_ECHO, C_CARET, 2'd0, 1'b0, 1'b0);
        r.w[1] = mk(K_ECHO, C_MARK_Z, 2'd0, 1'b0, 1'b0);
        r.w[2] = mk(K_ECHO, C_LF, 2'd0, 1'b0, 1'b0);
        r.w[3] = mk(K_SIG, 8'd26, SIG_SUSP, 1'b0, 1'b1); rows.push_back(r);
        r = '{op: 1'b0, rx: 8'hFF, typed: 1, n: 1, w: '{default: '0}};
        r.w[0] = mk(K_ECHO, 8'hFF, 2'd0, 1'b0, 1'b1); rows.push_back(r);
        r = '{op: 1'b0, rx: 8'h00, typed: 0, n: 0, w: '{default: '0}}; rows.push_back(r);
        r = '{op: 1'b0, rx: 8'h55, typed: 0, n: 0, w: '{default: '0}}; rows.push_back(r);
        r = '{op: 1'b0, rx: C_DEL, typed: 0, n: 0, w: '{default: '0}}; rows.push_back(r);
        r = '{op: 1'b1, rx: 8'h00, typed: 1, n: 1, w: '{default: '0}};
        r.w[0] = mk(K_EMPTY, 8'd0, 2'd0, 1'b0, 1'b1); rows.push_back(r);
        r = '{op: 1'b0, rx: C_CR, typed: 0, n: 0, w: '{default: '0}}; rows.push_back(r);
        for (int i = 0; i < 4; i++) begin
            r = '{op: 1'b1, rx: 8'hAA, typed: 0, n: 0, w: '{default: '0}};
            rows.push_back(r);
        end

        foreach (rows[i]) begin
            if (rows[i].typed) begin
                for (int j = 0; j < rows[i].n; j++) pending_words.push_back(rows[i].w[j]);
                // model updates state but its words are replaced by the typed ones
                predict_editor(rows[i].op, rows[i].rx);
                repeat (step_words.size()) void'(pending_words.pop_back());
                send_raw(rows[i].op, rows[i].rx);
            end else begin
                send_word(rows[i].op, rows[i].rx);
            end
        end
        drain();

        random_phase(60);
        drain();

        // raw mode, signals off, extreme signal characters; then signals on, echo off
        write_reg(CFG_CANON, 8'd0);
        write_reg(CFG_SIG, 8'd0);
        write_reg(CFG_INTR, 8'hFF);
        write_reg(CFG_QUIT, 8'h00);
        write_reg(CFG_SUSP, 8'h7F);
        random_phase(40);
        drain();
        write_reg(CFG_SIG, 8'd1);
        write_reg(CFG_ECHO, 8'd0);
        random_phase(40);
        drain();

        for (int i = 0; i < 10; i++) send_word(1'b1, 8'd0);
        drain();

        write_reg(CFG_ECHO, 8'd1);
        write_reg(CFG_CANON, 8'd1);
        write_reg(CFG_INTR, 8'd3);
        write_reg(CFG_QUIT, 8'd28);
        write_reg(CFG_SUSP, 8'd26);
        random_phase(60);
        drain();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // handshake with prediction already queued
    task automatic send_raw(logic op, logic [7:0] rx);
        i_s_tvalid = 1'b1;
        i_s_tuser  = op;
        i_s_tdata  = rx;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

endmodule

[sim.f]
hdl/tle_pkg.sv
hdl/tle_ram.sv
hdl/tle_ctrl.sv
hdl/tle_dp.sv
hdl/tty_line_editor.sv
sim/tb_tty_line_editor.sv
